// ===== rtl/pps_pkg.sv =====
// package for the pitch period similarity block
// holds default sizes, fixed field widths and the transaction structs; no dependencies
package pps_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int LAG_W   = 12;
    localparam int SEED_W  = 11;
    localparam int QUOT_W  = 29;
    localparam int MAG_W   = 15;
    localparam int MIN_LAG = 8;
    localparam logic [16:0] RECIP5 = 17'd52429;
    localparam int RECIP5_SHIFT = 18;
    localparam logic signed [15:0] NONE_CODE = 16'sh8000;

    typedef struct packed {
        logic signed [15:0]  sample;
        logic [SEED_W-1:0]   seed_period;
        logic                first;
        logic                last;
    } pps_item_t;

    typedef struct packed {
        logic signed [15:0]  similarity;
        logic                found;
    } pps_result_t;

endpackage

// ===== rtl/pitch_period_similarity.sv =====
// pitch period similarity: window load, lag search and normalized correlation
// depends on pps_pkg
//
// usage: an input transaction is taken when start is high and busy is low.
// items may come back to back; a sample is stored while the memory has room.
// an item with last set starts the lag search; busy stays high until it ends.
// S_BOUND0 and S_BOUND1 set the lag bounds, then per lag come a check state,
// the correlation sums (one memory read pair a cycle), the two serial products
// run side by side, the serial division and the serial square root; a lag
// with zero energy skips the products, the division and the square root.
// results: done is high for one cycle with similarity and found on result,
// in the same cycle that busy drops; the receiver cannot stall.
// reset clears count, held period and control; window memory is not cleared,
// only entries written in the current window are read.
module pitch_period_similarity
    import pps_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  pps_item_t   item,
    output logic        busy,
    output logic        done,
    output pps_result_t result
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CW    = $clog2(STORE_DEPTH + 1);
    localparam int ACC_W = 2 * SAMPLE_BITS + AW;
    localparam int PW    = 2 * ACC_W;
    localparam int MSTEP = $clog2(ACC_W + 1);
    localparam int CMPW  = (CW > LAG_W + 1) ? CW : LAG_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_BOUND0, S_BOUND1, S_LAGCHK, S_MAC, S_MULT, S_DIV, S_SQRT
    } state_t;

    state_t state_reg;

    logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] a_data_reg, b_data_reg;
    logic [AW-1:0]          ra, rb, wa;
    logic                   we;

    logic [CW-1:0]      count_reg;
    logic [SEED_W-1:0]  period_reg;
    logic [29:0]        lo_prod_reg, hi_prod_reg;
    logic [LAG_W-1:0]   lag_reg, hi_reg, i_reg;
    logic               v1_reg, v2_reg;
    logic signed [2*SAMPLE_BITS-1:0] pab_reg, paa_reg, pbb_reg;
    logic signed [ACC_W-1:0] sab_reg;
    logic [ACC_W-1:0]   saa_reg, sbb_reg;
    logic               neg_reg;
    logic [PW-1:0]      mc1_reg, mc2_reg, pr1_reg, pr2_reg;
    logic [ACC_W-1:0]   mp1_reg, mp2_reg;
    logic [MSTEP-1:0]   step_reg;
    logic [PW:0]        rem_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [3:0]         bit_reg;
    logic signed [15:0] best_reg;
    logic               found_reg;
    logic               done_reg;
    pps_result_t        result_reg;

    logic               accept;
    logic [CW-1:0]      wr_count;
    logic [LAG_W-1:0]   lo_calc;
    logic [MAG_W-1:0]   cand;
    logic [2*MAG_W-1:0] cand_sq;
    logic               rem_ge;
    logic signed [15:0] val;
    logic [ACC_W-1:0]   abs_ab;
    logic               search_end;

    assign accept   = start && (state_reg == S_IDLE);
    assign wr_count = item.first ? '0 : count_reg;
    assign we       = accept && (wr_count < CW'(STORE_DEPTH));
    assign wa       = AW'(wr_count);
    assign ra       = AW'(i_reg);
    assign rb       = AW'({1'b0, lag_reg} + {1'b0, i_reg});

    assign lo_calc  = LAG_W'(lo_prod_reg >> RECIP5_SHIFT);
    assign cand     = mag_reg | (MAG_W'(1) << bit_reg);
    assign cand_sq  = cand * cand;
    assign rem_ge   = rem_reg >= {1'b0, pr2_reg};
    assign val      = neg_reg ? -$signed({1'b0, cand_sq <= 30'(quot_reg) ? cand : mag_reg})
                              : $signed({1'b0, cand_sq <= 30'(quot_reg) ? cand : mag_reg});
    assign abs_ab   = sab_reg[ACC_W-1] ? ACC_W'(-sab_reg) : ACC_W'(sab_reg);
    assign search_end = (lag_reg > hi_reg) ||
                        (CMPW'({lag_reg, 1'b0}) >= CMPW'(count_reg));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= SAMPLE_BITS'(item.sample[15:0]);
        end
        a_data_reg <= mem[ra];
        b_data_reg <= mem[rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            period_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            best_reg   <= NONE_CODE;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_LAGCHK) && search_end;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.first)
                        begin
                            period_reg <= item.seed_period;
                        end
                        count_reg <= we ? wr_count + CW'(1) : wr_count;
                        if (item.last)
                        begin
                            state_reg <= S_BOUND0;
                        end
                    end
                end
                S_BOUND0:
                begin
                    lo_prod_reg <= 30'({period_reg, 2'b00} * RECIP5);
                    hi_prod_reg <= 30'(({period_reg, 2'b00} + {1'b0, period_reg, 1'b0}) * RECIP5);
                    state_reg   <= S_BOUND1;
                end
                S_BOUND1:
                begin
                    lag_reg   <= (lo_calc < LAG_W'(MIN_LAG)) ? LAG_W'(MIN_LAG) : lo_calc;
                    hi_reg    <= LAG_W'(hi_prod_reg >> RECIP5_SHIFT);
                    best_reg  <= NONE_CODE;
                    found_reg <= 1'b0;
                    state_reg <= S_LAGCHK;
                end
                S_LAGCHK:
                begin
                    if (search_end)
                    begin
                        result_reg <= '{similarity: best_reg, found: found_reg};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        sab_reg   <= '0;
                        saa_reg   <= '0;
                        sbb_reg   <= '0;
                        i_reg     <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    v1_reg <= i_reg < lag_reg;
                    v2_reg <= v1_reg;
                    if (i_reg < lag_reg)
                    begin
                        i_reg <= i_reg + LAG_W'(1);
                    end
                    if (v1_reg)
                    begin
                        pab_reg <= $signed(a_data_reg) * $signed(b_data_reg);
                        paa_reg <= $signed(a_data_reg) * $signed(a_data_reg);
                        pbb_reg <= $signed(b_data_reg) * $signed(b_data_reg);
                    end
                    if (v2_reg)
                    begin
                        sab_reg <= sab_reg + ACC_W'(pab_reg);
                        saa_reg <= saa_reg + ACC_W'(unsigned'(paa_reg));
                        sbb_reg <= sbb_reg + ACC_W'(unsigned'(pbb_reg));
                    end
                    if (i_reg == lag_reg && !v1_reg && !v2_reg)
                    begin
                        if (saa_reg == '0 || sbb_reg == '0)
                        begin
                            lag_reg   <= lag_reg + LAG_W'(1);
                            state_reg <= S_LAGCHK;
                        end
                        else
                        begin
                            neg_reg   <= sab_reg[ACC_W-1];
                            mc1_reg   <= PW'(abs_ab);
                            mp1_reg   <= abs_ab;
                            mc2_reg   <= PW'(saa_reg);
                            mp2_reg   <= sbb_reg;
                            pr1_reg   <= '0;
                            pr2_reg   <= '0;
                            step_reg  <= MSTEP'(ACC_W);
                            state_reg <= S_MULT;
                        end
                    end
                end
                S_MULT:
                begin
                    if (mp1_reg[0])
                    begin
                        pr1_reg <= pr1_reg + mc1_reg;
                    end
                    if (mp2_reg[0])
                    begin
                        pr2_reg <= pr2_reg + mc2_reg;
                    end
                    mc1_reg  <= mc1_reg << 1;
                    mc2_reg  <= mc2_reg << 1;
                    mp1_reg  <= mp1_reg >> 1;
                    mp2_reg  <= mp2_reg >> 1;
                    if (step_reg == MSTEP'(1))
                    begin
                        rem_reg   <= {1'b0, pr1_reg + (mp1_reg[0] ? mc1_reg : '0)};
                        quot_reg  <= '0;
                        bit_reg   <= 4'd0;
                        step_reg  <= MSTEP'(QUOT_W);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        step_reg <= step_reg - MSTEP'(1);
                    end
                end
                S_DIV:
                begin
                    quot_reg <= {quot_reg[QUOT_W-2:0], rem_ge};
                    rem_reg  <= (rem_ge ? rem_reg - {1'b0, pr2_reg} : rem_reg) << 1;
                    step_reg <= step_reg - MSTEP'(1);
                    if (step_reg == MSTEP'(1))
                    begin
                        mag_reg   <= '0;
                        bit_reg   <= 4'(MAG_W - 1);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (cand_sq <= 30'(quot_reg))
                    begin
                        mag_reg <= cand;
                    end
                    bit_reg <= bit_reg - 4'd1;
                    if (bit_reg == 4'd0)
                    begin
                        if (!found_reg || val > best_reg)
                        begin
                            best_reg <= val;
                        end
                        found_reg <= 1'b1;
                        lag_reg   <= lag_reg + LAG_W'(1);
                        state_reg <= S_LAGCHK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/pps_checker.sv =====
// port level checks for pitch_period_similarity, attached by bind
// depends on pps_pkg
module pps_checker
    import pps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input pps_item_t   item,
    input logic        busy,
    input logic        done,
    input pps_result_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    a_none_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.similarity == NONE_CODE))
        else $error("no lag but similarity not the none code");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |->
        ($signed(result.similarity) <= 16'sd16384 && $signed(result.similarity) >= -16'sd16384))
        else $error("similarity out of range");

    a_plain_item: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last) |=> (!busy && !done))
        else $error("item without last started a search");

endmodule

bind pitch_period_similarity pps_checker u_pps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/pitch_period_similarity_tb.sv =====
// testbench for pitch_period_similarity: directed windows, then random windows
// an internal period-search predictor checks every similarity/found result; needs pps_pkg
`timescale 1ns / 1ps

module pitch_period_similarity_tb;
    import pps_pkg::*;

    localparam int DEPTH = 4096;
    localparam int CYCLE_LIMIT = 10_000_000;

    class window_correlator;
        int            window_mem[DEPTH];
        int unsigned   stored;
        int unsigned   seed_hold;
        pps_result_t   pending_results[$];
        int            errors;
        int            checked;

        function new();
            stored = 0;
            seed_hold = 0;
            errors = 0;
            checked = 0;
        endfunction

        // largest m in [0,16384] with m^2 * aa * bb <= 2^28 * ab^2
        function int ncc_q14(bit [63:0] ab, bit [63:0] aa, bit [63:0] bb);
            bit [127:0] energy_prod;
            bit [127:0] cross_sq;
            bit [127:0] lhs;
            bit [127:0] m2;
            int lo;
            int hi;
            int mid;
            energy_prod = {64'd0, aa} * {64'd0, bb};
            cross_sq = {64'd0, ab} * {64'd0, ab};
            cross_sq = cross_sq << 28;
            lo = 0;
            hi = 16384;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                m2 = mid * mid;
                lhs = energy_prod * m2;
                if (lhs <= cross_sq)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        function pps_result_t best_lag_similarity();
            pps_result_t r;
            int unsigned lo;
            int unsigned hi;
            int unsigned lag;
            longint sab;
            longint saa;
            longint sbb;
            int m;
            int v;
            int best;
            bit hit;
            best = -32768;
            hit = 0;
            lo = (4 * seed_hold) / 5;
            hi = (6 * seed_hold) / 5;
            if (lo < MIN_LAG)
                lo = MIN_LAG;
            for (lag = lo; lag <= hi; lag++)
            begin
                if (2 * lag >= stored)
                    continue;
                sab = 0;
                saa = 0;
                sbb = 0;
                for (int i = 0; i < lag; i++)
                begin
                    sab += longint'(window_mem[i]) * window_mem[lag + i];
                    saa += longint'(window_mem[i]) * window_mem[i];
                    sbb += longint'(window_mem[lag + i]) * window_mem[lag + i];
                end
                if (saa <= 0 || sbb <= 0)
                    continue;
                m = ncc_q14(sab < 0 ? -sab : sab, saa, sbb);
                v = sab < 0 ? -m : m;
                if (!hit || v > best)
                    best = v;
                hit = 1;
            end
            r.similarity = best[15:0];
            r.found = hit;
            return r;
        endfunction

        function void take_item(pps_item_t it);
            if (it.first)
            begin
                stored = 0;
                seed_hold = it.seed_period;
            end
            if (stored < DEPTH)
            begin
                window_mem[stored] = int'(it.sample);
                stored++;
            end
            if (it.last)
                pending_results.insert(pending_results.size(), best_lag_similarity());
        endfunction

        function void check_result(pps_result_t got);
            pps_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result similarity=%0d found=%0b",
                         $time, got.similarity, got.found);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.similarity !== want.similarity)
            begin
                $display("%0t: similarity mismatch expected %0d actual %0d",
                         $time, want.similarity, got.similarity);
                errors++;
            end
            if (got.found !== want.found)
            begin
                $display("%0t: found mismatch expected %0b actual %0b",
                         $time, want.found, got.found);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    pps_item_t   item;
    logic        busy;
    logic        done;
    pps_result_t result;

    window_correlator board;
    int unsigned cycles;
    int unsigned items_sent;
    int unsigned windows_sent;
    bit calm;

    pitch_period_similarity uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("pitch_period_similarity_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    // called at a rising edge; returns at the edge that took the transaction or, unless calm, after a random idle pause
    task send(input logic signed [15:0] s, input logic [10:0] seed,
              input logic fst, input logic lst);
        pps_item_t it;
        begin
            it.sample = s;
            it.seed_period = seed;
            it.first = fst;
            it.last = lst;
            start <= 1'b1;
            item <= it;
            do
                @(posedge clk);
            while (busy);
            board.take_item(it);
            items_sent++;
            if (!calm && $urandom_range(99) < 33)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    endtask

    task drain();
        begin
            start <= 1'b0;
            while (board.pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    function logic signed [15:0] clip(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    // one window: periodic content with noise, pure noise, or silence
    task run_window(input int seed, input int len, input int kind);
        int per;
        int amp;
        int shape[];
        begin
            per = seed + $urandom_range(0, 4) - 2;
            if (per < 1)
                per = 1;
            shape = new[per];
            amp = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(1, 20000);
            foreach (shape[i])
                shape[i] = $urandom_range(0, 2 * amp) - amp;
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    0: send(clip(shape[i % per] + $urandom_range(0, 2000) - 1000),
                            11'(seed), i == 0, i == len - 1);
                    1: send(16'($urandom_range(0, 65535)), 11'(seed), i == 0, i == len - 1);
                    default: send(16'sd0, 11'(seed), i == 0, i == len - 1);
                endcase
            end
            windows_sent++;
        end
    endtask

    initial
    begin
        int seed;
        int len;
        int kind;
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cycles = 0;
        items_sent = 0;
        windows_sent = 0;
        calm = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // samples before any first: held period is zero
        send(16'sd32767, 11'd0, 1'b0, 1'b0);
        send(-16'sd32768, 11'd5, 1'b0, 1'b0);
        send(16'sd1, 11'd0, 1'b0, 1'b1);
        // first and last on the same transaction
        send(16'sd1234, 11'd100, 1'b1, 1'b1);
        // alternating extremes at period 8, then more samples and another search
        for (int i = 0; i < 18; i++)
            send((i % 8) < 4 ? 16'sd32767 : -16'sd32768, 11'd8, i == 0, i == 17);
        send(-16'sd32768, 11'd0, 1'b0, 1'b0);
        send(16'sd32767, 11'd3, 1'b0, 1'b1);
        // silent window gives no qualifying lag
        for (int i = 0; i < 25; i++)
            send(16'sd0, 11'd10, i == 0, i == 24);
        // the largest seed and a large one, too few samples stored
        send(16'sd77, 11'd2047, 1'b1, 1'b0);
        send(-16'sd77, 11'd0, 1'b0, 1'b1);
        send(16'sd5, 11'd1024, 1'b1, 1'b0);
        send(16'sd9, 11'd0, 1'b0, 1'b1);
        drain();

        // overfilled window: only the first samples are kept
        for (int i = 0; i < DEPTH + 8; i++)
            send(16'($urandom_range(0, 65535)), 11'd20, i == 0, i == DEPTH + 7);
        drain();

        while (items_sent < DEPTH + 60 + 1000 || windows_sent < 60)
        begin
            calm = (items_sent > DEPTH + 400 && items_sent < DEPTH + 650);
            case ($urandom_range(0, 19))
                0: seed = $urandom_range(1, 7);
                1: seed = $urandom_range(100, 250);
                default: seed = $urandom_range(8, 48);
            endcase
            len = 2 * seed + $urandom_range(0, seed + 4);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, 2 * seed + 2);
            kind = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
            run_window(seed, len, kind);
            // occasional stray samples after a window, sometimes searched again
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 5))
                    send(16'($urandom_range(0, 65535)), 11'($urandom_range(0, 2047)),
                         1'b0, 1'b0);
                if ($urandom_range(0, 1))
                    send(16'($urandom_range(0, 65535)), 11'd0, 1'b0, 1'b1);
            end
        end

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d transactions in %0d windows, %0d results checked",
                 items_sent, windows_sent, board.checked);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("pitch_period_similarity_tb OK");
        else
            $display("pitch_period_similarity_tb NOT OK");
        $finish;
    end
endmodule
